// ----- src/bounded_top_k_min_heap_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the bounded top-K heap
// Concurrent checks clocked on clk, held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_TOP_K_MIN_HEAP_TOP_DEFINES_SVH
`define BOUNDED_TOP_K_MIN_HEAP_TOP_DEFINES_SVH

// same-cycle implication
`define BTKMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTKMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/btkmh_pkg.sv -----
// ---------------------------------------------------------------------------
// btkmh_pkg
// Shared sizes, payload structs and codes for the bounded top-K heap.
// ---------------------------------------------------------------------------
`default_nettype none

package btkmh_pkg;

  localparam int DEPTH      = 64;
  localparam int KEY_BITS   = 64;
  localparam int TAG_BITS   = 16;
  localparam int CAP_BITS   = 7;
  localparam int FILL_BITS  = 7;
  localparam int CAP_RESET  = 64;

  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  // child index 2*pos+2 fits in one more bit than the count
  localparam int IDX_BITS   = CNT_BITS + 1;
  localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
  localparam int ENTRY_BITS = KEY_BITS + TAG_BITS;

  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_POP   = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  typedef struct packed {
    logic mode;
    key_t key;
    tag_t tag;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 out_valid;
    key_t                 out_key;
    tag_t                 out_tag;
    logic [FILL_BITS-1:0] fill_count;
  } out_item_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/bounded_top_k_min_heap_top.sv -----
// Path, accept edge to out_valid: a plain insert sifts up, a pop sifts down, a reject or
//   empty pop goes straight to the result register, and a replace of the minimum on a
//   full heap sifts down and then up; each sift moves one level at a time.
// Throughput: one item in flight, one RAM access per level; in_ready only in
//   idle, from the cycle after the result register loads. Reset (rst_n, sync,
//   active low): fill 0, capacity 64, no result pending; heap RAM not cleared.
// ---------------------------------------------------------------------------
// bounded_top_k_min_heap_top
// Keeps the K largest keys with tags in a binary min-heap held in RAM.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bounded_top_k_min_heap_top_defines.svh"

module bounded_top_k_min_heap_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire btkmh_pkg::in_item_t                 in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output btkmh_pkg::out_item_t                     out_data,
  // capacity register
  input  wire logic                                cfg_wr_en,
  input  wire logic [btkmh_pkg::CAP_BITS-1:0]      cfg_wr_data
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;  // wait for an input transfer
  localparam logic [2:0] S_DECIDE = 3'd1;  // root and last slot on read data
  localparam logic [2:0] S_SD     = 3'd2;  // sift-down, one level per cycle
  localparam logic [2:0] S_SU_RD  = 3'd3;  // issue first parent read
  localparam logic [2:0] S_SU     = 3'd4;  // sift-up, one level per cycle
  localparam logic [2:0] S_FIN    = 3'd5;  // load output register

  localparam int AW = btkmh_pkg::ADDR_BITS;
  localparam int CW = btkmh_pkg::CNT_BITS;
  localparam int IW = btkmh_pkg::IDX_BITS;
  localparam int MW = btkmh_pkg::CMP_BITS;

  logic [2:0]                       state_r, state_nxt;
  logic [btkmh_pkg::CAP_BITS-1:0]   cap_r, cap_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [AW-1:0]                    pos_r, pos_nxt;
  logic [IW-1:0]                    child_r, child_nxt;
  btkmh_pkg::entry_t                mk_r, mk_nxt;      // entry being sifted down
  btkmh_pkg::entry_t                nk_r, nk_nxt;      // offered entry
  logic                             mode_r, mode_nxt;
  logic                             ins_pend_r, ins_pend_nxt;
  btkmh_pkg::out_item_t             res_r, res_nxt;
  btkmh_pkg::out_item_t             out_r, out_nxt;
  logic                             ov_r, ov_nxt;

  // RAM port signals
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  btkmh_pkg::entry_t                ram_wdata;
  logic [AW-1:0]                    ram_ra, ram_rb;
  logic [btkmh_pkg::ENTRY_BITS-1:0] ram_qa, ram_qb;
  btkmh_pkg::entry_t                rd_a, rd_b;

  // Shared compare datapath terms
  logic [MW-1:0]                    cap_ext, eff_cap, cnt_ext;
  logic [IW-1:0]                    cnt_idx, right_idx, next_child;
  logic                             take_right;
  btkmh_pkg::entry_t                sel;
  logic [AW-1:0]                    sel_idx, par, par2;

  assign rd_a = ram_qa;
  assign rd_b = ram_qb;

  // K clamped to 1..DEPTH
  assign cap_ext = MW'(cap_r);
  assign cnt_ext = MW'(cnt_r);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = MW'(1);
    end else if (cap_ext > MW'(btkmh_pkg::DEPTH)) begin
      eff_cap = MW'(btkmh_pkg::DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Sift-down child pick: right wins ties
  assign cnt_idx    = IW'(cnt_r);
  assign right_idx  = child_r + IW'(1);
  assign take_right = (right_idx < cnt_idx) && (rd_b.key <= rd_a.key);
  assign sel        = take_right ? rd_b : rd_a;
  assign sel_idx    = take_right ? right_idx[AW-1:0] : child_r[AW-1:0];
  assign next_child = IW'({sel_idx, 1'b1});

  // Sift-up parents
  assign par  = AW'((pos_r - AW'(1)) >> 1);
  assign par2 = AW'((par - AW'(1)) >> 1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt    = state_r;
    cap_nxt      = cap_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    child_nxt    = child_r;
    mk_nxt       = mk_r;
    nk_nxt       = nk_r;
    mode_nxt     = mode_r;
    ins_pend_nxt = ins_pend_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    ov_nxt       = ov_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = mk_r;
    ram_ra       = '0;
    ram_rb       = '0;

    if (cfg_wr_en) begin
      cap_nxt = cfg_wr_data;
    end
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // root and last slot come back next cycle
        ram_ra = '0;
        ram_rb = AW'(cnt_r - CW'(1));
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          nk_nxt.key = in_data.key;
          nk_nxt.tag = in_data.tag;
          state_nxt  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_nxt.accepted  = 1'b0;
        res_nxt.out_valid = 1'b0;
        res_nxt.out_key   = '0;
        res_nxt.out_tag   = '0;
        ins_pend_nxt      = 1'b0;
        state_nxt         = S_FIN;
        if (mode_r == btkmh_pkg::MODE_POP) begin
          if (cnt_r != '0) begin
            res_nxt.out_valid = 1'b1;
            res_nxt.out_key   = rd_a.key;
            res_nxt.out_tag   = rd_a.tag;
            cnt_nxt   = cnt_r - CW'(1);
            mk_nxt    = rd_b;
            pos_nxt   = '0;
            child_nxt = IW'(1);
            ram_ra    = AW'(1);
            ram_rb    = AW'(2);
            state_nxt = S_SD;
          end
        end else if (cnt_ext < eff_cap) begin
          res_nxt.accepted = 1'b1;
          pos_nxt   = cnt_r[AW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_SU_RD;
        end else if ((cnt_r != '0) && (rd_a.key <= nk_r.key)) begin
          // replace the minimum: remove root, then insert the offer
          res_nxt.accepted  = 1'b1;
          res_nxt.out_valid = 1'b1;
          res_nxt.out_key   = rd_a.key;
          res_nxt.out_tag   = rd_a.tag;
          ins_pend_nxt = 1'b1;
          cnt_nxt   = cnt_r - CW'(1);
          mk_nxt    = rd_b;
          pos_nxt   = '0;
          child_nxt = IW'(1);
          ram_ra    = AW'(1);
          ram_rb    = AW'(2);
          state_nxt = S_SD;
        end
      end

      S_SD: begin
        ram_we = 1'b1;
        if ((child_r >= cnt_idx) || (mk_r.key <= sel.key)) begin
          // settle the moved entry here
          ram_wdata = mk_r;
          if (ins_pend_r) begin
            ins_pend_nxt = 1'b0;
            pos_nxt   = cnt_r[AW-1:0];
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_SU_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          // pull the smaller child up, descend
          ram_wdata = sel;
          pos_nxt   = sel_idx;
          child_nxt = next_child;
          ram_ra    = next_child[AW-1:0];
          ram_rb    = AW'(next_child + IW'(1));
        end
      end

      S_SU_RD: begin
        ram_ra    = par;
        state_nxt = S_SU;
      end

      S_SU: begin
        ram_we = 1'b1;
        if ((pos_r == '0) || (rd_a.key <= nk_r.key)) begin
          ram_wdata = nk_r;
          state_nxt = S_FIN;
        end else begin
          // parent moves down, climb
          ram_wdata = rd_a;
          pos_nxt   = par;
          ram_ra    = par2;
        end
      end

      S_FIN: begin
        if (!ov_r || out_ready) begin
          out_nxt            = res_r;
          out_nxt.fill_count = btkmh_pkg::FILL_BITS'(cnt_r);
          ov_nxt             = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cap_r      <= btkmh_pkg::CAP_BITS'(btkmh_pkg::CAP_RESET);
      cnt_r      <= '0;
      ins_pend_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cap_r      <= cap_nxt;
      cnt_r      <= cnt_nxt;
      ins_pend_r <= ins_pend_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    child_r <= child_nxt;
    mk_r    <= mk_nxt;
    nk_r    <= nk_nxt;
    mode_r  <= mode_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  btkmh_ram #(
    .WIDTH (btkmh_pkg::ENTRY_BITS),
    .DEPTH (btkmh_pkg::DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .rdata_a (ram_qa),
    .raddr_b (ram_rb),
    .rdata_b (ram_qb)
  );

  // Checks
  `BTKMH_ASSERT_NOW(a_fill_bound, 1'b1, cnt_r <= CW'(btkmh_pkg::DEPTH), "fill above depth")
  `BTKMH_ASSERT_NOW(a_sd_pos, state_r == S_SD, (pos_r == '0) || (IW'(pos_r) < cnt_idx), "sift-down slot past fill")
  `BTKMH_ASSERT_NOW(a_su_pos, state_r == S_SU, (cnt_r != '0) && (IW'(pos_r) < cnt_idx), "sift-up slot past fill")
  `BTKMH_ASSERT_NEXT(a_fin_load, (state_r == S_FIN) && !ov_r, ov_r && (state_r == S_IDLE), "result not loaded")

endmodule

`default_nettype wire

// ----- src/btkmh_ram.sv -----
// ---------------------------------------------------------------------------
// btkmh_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module btkmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic      [WIDTH-1:0]                         rdata_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire
